// ===== rtl/dlk_pkg.sv =====
// shared types and constants for the degree-limited kruskal tree block
`default_nettype none
package dlk_pkg;
	localparam int unsigned MAX_VERTICES = 64;
	localparam int unsigned MAX_EDGES_DEF = 256;
	localparam int unsigned WEIGHT_BITS = 16;
	localparam int unsigned VW = 6;
	localparam int unsigned NW = 7;
	localparam int unsigned DW = 6;
	localparam int unsigned SUM_W = 22;
	localparam int unsigned IN_TDATA_W = 32;
	localparam int unsigned OUT_TDATA_W = 24;
	localparam int unsigned CFG_W = 7;

	localparam logic REG_VERTEX_COUNT = 1'b0;
	localparam logic REG_MAX_DEGREE = 1'b1;

	localparam logic [NW-1:0] VC_RESET = 7'd64;
	localparam logic [DW-1:0] MD_RESET = 6'd2;

	typedef struct packed {
		logic signed [WEIGHT_BITS-1:0] w;
		logic [VW-1:0] b;
		logic [VW-1:0] a;
	} dlk_edge_t;

	typedef struct packed {
		logic load;
		logic shift;
	} dlk_ectl_t;

	typedef struct packed {
		logic init;
		logic join_en;
		logic [VW-1:0] a;
		logic [VW-1:0] b;
		logic [VW-1:0] la;
		logic [VW-1:0] lb;
	} dlk_vctl_t;
endpackage
`default_nettype wire

// ===== rtl/dlk_edge_cell.sv =====
// one slot of the sorted edge chain: insert in order while loading, shift out during the pass
`default_nettype none
module dlk_edge_cell import dlk_pkg::*; #(
	parameter int unsigned IDX = 0,
	parameter int unsigned CW = 9
) (
	input  wire logic      clk,
	input  wire dlk_ectl_t ctl,
	input  wire logic [CW-1:0] count,
	input  wire dlk_edge_t new_e,
	input  wire dlk_edge_t left_e,
	input  wire logic      left_gt,
	input  wire dlk_edge_t right_e,
	output dlk_edge_t      edge_q,
	output logic           gt
);
	logic occ;
	logic at_end;

	assign occ = CW'(IDX) < count;
	assign at_end = CW'(IDX) == count;
	// strict compare keeps equal weights in arrival order
	assign gt = occ && ($signed(edge_q.w) > $signed(new_e.w));

	always_ff @(posedge clk) begin
		if (ctl.load && (gt || at_end)) begin
			edge_q <= left_gt ? left_e : new_e;
		end else if (ctl.shift) begin
			edge_q <= right_e;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/dlk_vertex_cell.sv =====
// per-vertex component label, tree degree and touched flag
`default_nettype none
module dlk_vertex_cell import dlk_pkg::*; #(
	parameter int unsigned IDX = 0
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire dlk_vctl_t ctl,
	output logic [VW-1:0]  label_q,
	output logic [DW-1:0]  deg_q,
	output logic           touched_q
);
	logic is_end;

	assign is_end = (ctl.a == VW'(IDX)) || (ctl.b == VW'(IDX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			label_q <= VW'(IDX);
			deg_q <= '0;
			touched_q <= 1'b0;
		end else if (ctl.init) begin
			label_q <= VW'(IDX);
			deg_q <= '0;
			touched_q <= 1'b0;
		end else if (ctl.join_en) begin
			// merging relabels the whole component of end b
			if (label_q == ctl.lb) begin
				label_q <= ctl.la;
			end
			if (is_end) begin
				deg_q <= deg_q + DW'(1);
				touched_q <= 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/degree_limited_kruskal_tree_top.sv =====
// Degree-limited Kruskal spanning tree. Edges load at one item per cycle into a chain of
// MAX_EDGES cells that keeps them sorted by weight (ties in arrival order) as they arrive.
// The item with tlast starts the pass: the chain shifts one edge per cycle into a row of
// MAX_VERTICES vertex cells holding component labels and degrees until every stored edge
// is seen or the tree completes early, and the result is registered once the output is
// free; input is not taken during the pass. Edges beyond MAX_EDGES are dropped and
// reported in the result's overflow flag.
`default_nettype none
module degree_limited_kruskal_tree_top import dlk_pkg::*; #(
	parameter int unsigned MAX_EDGES = MAX_EDGES_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,  // end_a, end_b, weight, zero pad
	input  wire logic                   s_tlast,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata,  // total_weight, zero pad
	output logic [1:0]                  m_tuser,  // found, overflowed
	input  wire logic                   cfg_we,
	input  wire logic                   cfg_index,
	input  wire logic [CFG_W-1:0]       cfg_data
);
	localparam int unsigned CW = $clog2(MAX_EDGES + 1);
	localparam logic ST_LOAD = 1'b0;
	localparam logic ST_PASS = 1'b1;

	logic state_q;
	logic [NW-1:0] vc_q;
	logic [DW-1:0] md_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] k_q;
	logic dropped_q;
	logic [NW-1:0] te_q;
	logic signed [SUM_W-1:0] sum_q;
	logic out_valid_q;
	logic out_found_q;
	logic out_ovf_q;
	logic [SUM_W-1:0] out_sum_q;

	dlk_edge_t new_e;
	dlk_edge_t cell_e [MAX_EDGES];
	logic cell_gt [MAX_EDGES];
	dlk_ectl_t ectl;
	dlk_vctl_t vctl;
	logic [VW-1:0] lab [MAX_VERTICES];
	logic [DW-1:0] deg [MAX_VERTICES];
	logic touch [MAX_VERTICES];

	logic accept;
	logic full;
	dlk_edge_t head;
	logic [NW-1:0] n;
	logic [NW-1:0] nm1;
	logic stop;
	logic [VW-1:0] la;
	logic [VW-1:0] lb;
	logic [DW-1:0] da;
	logic [DW-1:0] db;
	logic ta;
	logic tb;
	logic any_over;
	logic take;
	logic found;
	logic out_free;
	logic done;

	assign new_e.a = s_tdata[VW-1:0];
	assign new_e.b = s_tdata[2*VW-1:VW];
	assign new_e.w = s_tdata[2*VW+WEIGHT_BITS-1:2*VW];

	assign s_tready = (state_q == ST_LOAD);
	assign accept = s_tvalid && s_tready;
	assign full = (cnt_q == CW'(MAX_EDGES));
	assign head = cell_e[0];

	assign n = (vc_q > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : vc_q;
	assign nm1 = n - NW'(1);
	assign stop = (n == '0) || (k_q == cnt_q) || (te_q == nm1);
	assign out_free = !out_valid_q || m_tready;
	assign done = (state_q == ST_PASS) && stop && out_free;

	always_comb begin
		la = '0;
		lb = '0;
		da = '0;
		db = '0;
		ta = 1'b0;
		tb = 1'b0;
		any_over = 1'b0;
		for (int v = 0; v < MAX_VERTICES; v++) begin
			if (head.a == VW'(v)) begin
				la |= lab[v];
				da |= deg[v];
				ta |= touch[v];
			end
			if (head.b == VW'(v)) begin
				lb |= lab[v];
				db |= deg[v];
				tb |= touch[v];
			end
			if ((NW'(v) < n) && (deg[v] > md_q)) begin
				any_over = 1'b1;
			end
		end
	end

	always_comb begin
		take = (state_q == ST_PASS) && !stop
			&& ({1'b0, head.a} < n) && ({1'b0, head.b} < n)
			&& (la != lb)
			&& !(ta && (da >= md_q)) && !(tb && (db >= md_q));
		found = (n != '0) && (te_q == nm1) && !any_over;
	end

	assign ectl.load = accept && !full;
	assign ectl.shift = (state_q == ST_PASS) && !stop;

	assign vctl.init = accept && s_tlast;
	assign vctl.join_en = take;
	assign vctl.a = head.a;
	assign vctl.b = head.b;
	assign vctl.la = la;
	assign vctl.lb = lb;

	for (genvar i = 0; i < MAX_EDGES; i++) begin : g_edge
		dlk_edge_t left_e;
		logic left_gt;
		dlk_edge_t right_e;
		if (i == 0) begin : g_first
			assign left_e = new_e;
			assign left_gt = 1'b0;
		end else begin : g_mid
			assign left_e = cell_e[i-1];
			assign left_gt = cell_gt[i-1];
		end
		if (i == MAX_EDGES - 1) begin : g_tail
			assign right_e = cell_e[i];
		end else begin : g_body
			assign right_e = cell_e[i+1];
		end
		dlk_edge_cell #(.IDX(i), .CW(CW)) u_cell (
			.clk(clk), .ctl(ectl), .count(cnt_q), .new_e(new_e),
			.left_e(left_e), .left_gt(left_gt), .right_e(right_e),
			.edge_q(cell_e[i]), .gt(cell_gt[i])
		);
	end

	for (genvar v = 0; v < MAX_VERTICES; v++) begin : g_vert
		dlk_vertex_cell #(.IDX(v)) u_vcell (
			.clk(clk), .arst_n(arst_n), .ctl(vctl),
			.label_q(lab[v]), .deg_q(deg[v]), .touched_q(touch[v])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= VC_RESET;
			md_q <= MD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_VERTEX_COUNT: vc_q <= cfg_data[NW-1:0];
				REG_MAX_DEGREE:   md_q <= cfg_data[DW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q <= '0;
			k_q <= '0;
			dropped_q <= 1'b0;
			te_q <= '0;
			sum_q <= '0;
			out_valid_q <= 1'b0;
			out_found_q <= 1'b0;
			out_ovf_q <= 1'b0;
			out_sum_q <= '0;
		end else begin
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (full) begin
							dropped_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + CW'(1);
						end
						if (s_tlast) begin
							state_q <= ST_PASS;
							k_q <= '0;
							te_q <= '0;
							sum_q <= '0;
						end
					end
				end
				ST_PASS: begin
					if (!stop) begin
						k_q <= k_q + CW'(1);
						if (take) begin
							te_q <= te_q + NW'(1);
							sum_q <= sum_q + SUM_W'($signed(head.w));
						end
					end else if (out_free) begin
						out_found_q <= found;
						out_sum_q <= found ? sum_q : '0;
						out_ovf_q <= dropped_q;
						cnt_q <= '0;
						dropped_q <= 1'b0;
						state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {{(OUT_TDATA_W-SUM_W){1'b0}}, out_sum_q};
	assign m_tuser = {out_ovf_q, out_found_q};

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_EDGES)) else $error("edge count beyond store");
	a_te_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PASS) && (n != '0) |-> te_q <= nm1)
		else $error("too many tree edges");
	a_zero_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_found_q |-> out_sum_q == '0)
		else $error("weight reported without a tree");
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dropped_q) |-> $past(cnt_q) == CW'(MAX_EDGES))
		else $error("edge dropped while store had room");
`endif
endmodule
`default_nettype wire

// ===== dv/degree_limited_kruskal_tree_checker.sv =====
// checker: predicts degree-limited kruskal results from observed items and compares them
module degree_limited_kruskal_tree_checker import dlk_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	input  wire logic [IN_TDATA_W-1:0] s_tdata,
	input  wire logic                  s_tlast,
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic [OUT_TDATA_W-1:0] m_tdata,
	input  wire logic [1:0]            m_tuser,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data,
	output int                         errors,
	output int                         pending
);
	typedef struct packed {
		logic             found;
		logic [SUM_W-1:0] total;
		logic             ovf;
	} tree_result_t;

	dlk_edge_t    graph_edges[$];
	logic         graph_dropped;
	logic [NW-1:0] vcount;
	logic [DW-1:0] dlimit;
	tree_result_t tree_q[$];

	function automatic int find_root(ref int par[MAX_VERTICES], input int v);
		int r;
		int nx;
		r = v;
		while (par[r] != r) r = par[r];
		while (par[v] != r) begin
			nx = par[v];
			par[v] = r;
			v = nx;
		end
		return r;
	endfunction

	function automatic tree_result_t build_tree(dlk_edge_t es[$], logic drp,
			logic [NW-1:0] vc, logic [DW-1:0] md);
		tree_result_t res;
		dlk_edge_t sorted[$];
		int par[MAX_VERTICES];
		int rnk[MAX_VERTICES];
		int deg[MAX_VERTICES];
		bit tch[MAX_VERTICES];
		int n;
		int taken;
		int j;
		int ra;
		int rb;
		logic signed [SUM_W-1:0] sum;
		bit ok;
		res.ovf = drp;
		res.found = 0;
		res.total = '0;
		n = (vc > MAX_VERTICES) ? MAX_VERTICES : int'(vc);
		if (n == 0) return res;
		for (int i = 0; i < MAX_VERTICES; i++) begin
			par[i] = i;
			rnk[i] = 0;
			deg[i] = 0;
			tch[i] = 0;
		end
		// stable insertion by weight
		foreach (es[i]) begin
			j = sorted.size();
			while (j > 0 && sorted[j-1].w > es[i].w) j--;
			sorted.insert(j, es[i]);
		end
		sum = '0;
		taken = 0;
		foreach (sorted[i]) begin
			if (taken == n - 1) break;
			if (sorted[i].a >= n || sorted[i].b >= n) continue;
			ra = find_root(par, sorted[i].a);
			rb = find_root(par, sorted[i].b);
			if (ra == rb) continue;
			if (tch[sorted[i].a] && deg[sorted[i].a] >= md) continue;
			if (tch[sorted[i].b] && deg[sorted[i].b] >= md) continue;
			if (rnk[ra] < rnk[rb]) begin
				j = ra;
				ra = rb;
				rb = j;
			end
			par[rb] = ra;
			if (rnk[ra] == rnk[rb]) rnk[ra]++;
			sum += SUM_W'(sorted[i].w);
			deg[sorted[i].a]++;
			deg[sorted[i].b]++;
			tch[sorted[i].a] = 1;
			tch[sorted[i].b] = 1;
			taken++;
		end
		ok = (taken == n - 1);
		for (int i = 0; i < n; i++) if (deg[i] > md) ok = 0;
		res.found = ok;
		res.total = ok ? sum : '0;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tree_result_t exp_r;
		if (!arst_n) begin
			graph_edges.delete();
			graph_dropped = 1'b0;
			vcount <= VC_RESET;
			dlimit <= MD_RESET;
			errors <= 0;
			tree_q.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_VERTEX_COUNT) vcount <= cfg_data;
				else dlimit <= cfg_data[DW-1:0];
			end
			if (s_tvalid && s_tready) begin
				if (graph_edges.size() < MAX_EDGES_DEF) begin
					graph_edges.insert(graph_edges.size(),
						dlk_edge_t'(s_tdata[VW*2+WEIGHT_BITS-1:0]));
				end else begin
					graph_dropped = 1'b1;
				end
				if (s_tlast) begin
					tree_q.insert(tree_q.size(),
						build_tree(graph_edges, graph_dropped, vcount, dlimit));
					graph_edges.delete();
					graph_dropped = 1'b0;
				end
			end
			if (m_tvalid && m_tready) begin
				if (tree_q.size() == 0) begin
					$display("%0t: unexpected result found=%b total=%h ovf=%b", $time,
						m_tuser[0], m_tdata[SUM_W-1:0], m_tuser[1]);
					errors <= errors + 1;
				end else begin
					exp_r = tree_q.pop_front();
					if (m_tuser[0] !== exp_r.found || m_tdata[SUM_W-1:0] !== exp_r.total ||
							m_tuser[1] !== exp_r.ovf || m_tdata[OUT_TDATA_W-1:SUM_W] !== '0) begin
						$display("%0t: expected found=%b total=%h ovf=%b, got found=%b total=%h ovf=%b",
							$time, exp_r.found, exp_r.total, exp_r.ovf, m_tuser[0],
							m_tdata, m_tuser[1]);
						errors <= errors + 1;
					end
				end
			end
			pending <= tree_q.size();
		end
	end
endmodule

// ===== dv/degree_limited_kruskal_tree_top_test.sv =====
// testbench top: drives edge graphs and config, reports the verdict
module degree_limited_kruskal_tree_top_test;
	import dlk_pkg::*;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   s_tlast;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [1:0]             m_tuser;
	logic                   cfg_we;
	logic                   cfg_index;
	logic [CFG_W-1:0]       cfg_data;
	int                     errors;
	int                     pending;
	int                     cycles;
	int                     burst_left;
	int                     stall_mode;

	degree_limited_kruskal_tree_top dut (.*);
	degree_limited_kruskal_tree_checker chk (.*);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("status: fail");
			$finish;
		end
	end

	// receiver stall pattern switches at random between modes
	always @(posedge clk) begin
		if (($urandom & 255) == 0) stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
		0: m_tready <= 1'b1;
		1: m_tready <= ($urandom & 3) != 0;
		default: m_tready <= ($urandom & 7) == 0;
		endcase
	end

	function automatic logic [IN_TDATA_W-1:0] pack_edge(int a, int b, int w);
		dlk_edge_t e;
		e.a = VW'(a);
		e.b = VW'(b);
		e.w = WEIGHT_BITS'(w);
		return IN_TDATA_W'(e);
	endfunction

	task automatic send_edge(int a, int b, int w, bit lst);
		// gaps between bursts
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
		end else begin
			burst_left--;
		end
		s_tvalid <= 1'b1;
		s_tdata <= pack_edge(a, b, w);
		s_tlast <= lst;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (MAX_EDGES_DEF + 20) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, int val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic int rand_w(int spread);
		if (spread == 0) return $urandom_range(0, 65535) - 32768;
		return $urandom_range(0, spread);
	endfunction

	// random graph: mostly spanning chains plus extra edges, some noise
	task automatic send_graph(int nv, int ne, int spread);
		int perm[$];
		int a;
		int b;
		for (int i = 0; i < nv; i++) perm.insert($urandom_range(0, perm.size()), i);
		for (int i = 0; i < ne; i++) begin
			if (i < nv - 1 && ($urandom & 3) != 0) begin
				a = perm[i];
				b = perm[i+1];
			end else if (($urandom & 15) == 0) begin
				a = $urandom_range(0, 63);
				b = $urandom_range(0, 63);
			end else begin
				a = $urandom_range(0, nv > 0 ? nv - 1 : 0);
				b = $urandom_range(0, nv > 0 ? nv - 1 : 0);
			end
			send_edge(a, b, rand_w(spread), i == ne - 1);
		end
	endtask

	initial begin
		int sent;
		int nv;
		int md;
		int ne;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_VERTEX_COUNT;
		cfg_data = '0;
		cycles = 0;
		burst_left = 0;
		stall_mode = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes with reset config
		send_edge(0, 63, 32767, 0);
		send_edge(63, 0, -32768, 0);
		send_edge(5, 5, 0, 0);
		send_edge(1, 2, -1, 1);
		settle();
		write_reg(REG_VERTEX_COUNT, 1);
		write_reg(REG_MAX_DEGREE, 0);
		send_edge(0, 1, 7, 1);
		settle();
		write_reg(REG_VERTEX_COUNT, 0);
		send_edge(0, 0, 3, 1);
		settle();
		write_reg(REG_VERTEX_COUNT, 127);
		write_reg(REG_MAX_DEGREE, 63);
		send_edge(0, 1, 100, 0);
		send_edge(1, 2, 100, 0);
		send_edge(0, 2, 100, 1);
		settle();
		write_reg(REG_VERTEX_COUNT, 2);
		write_reg(REG_MAX_DEGREE, 0);
		send_edge(0, 1, 10, 0);
		send_edge(1, 0, 10, 1);
		settle();
		write_reg(REG_VERTEX_COUNT, 3);
		write_reg(REG_MAX_DEGREE, 1);
		send_edge(0, 1, 4, 0);
		send_edge(1, 2, 4, 0);
		send_edge(0, 2, 9, 1);
		settle();
		// store overflow, last edge dropped too
		write_reg(REG_VERTEX_COUNT, 8);
		write_reg(REG_MAX_DEGREE, 2);
		send_graph(8, MAX_EDGES_DEF + 3, 0);
		settle();

		sent = 0;
		while (sent < 1100) begin
			nv = ($urandom & 7) == 0 ? $urandom_range(0, 127) : $urandom_range(1, 12);
			md = ($urandom & 3) == 0 ? $urandom_range(0, 63) : $urandom_range(0, 3);
			write_reg(REG_VERTEX_COUNT, nv);
			write_reg(REG_MAX_DEGREE, md);
			for (int g = 0; g < 4; g++) begin
				ne = $urandom_range(1, 20);
				send_graph(nv > 64 ? 64 : nv, ne, ($urandom & 1) ? 0 : 3);
				sent += ne;
			end
			settle();
		end
		write_reg(REG_VERTEX_COUNT, 64);
		write_reg(REG_MAX_DEGREE, 63);
		send_graph(64, 200, 0);
		send_graph(64, MAX_EDGES_DEF, 0);
		settle();

		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
